FILE: hdl/gtp_pkg.sv
// Package for the go-to-point motion controller.
// Holds request and mode codes, CORDIC constants and the arctangent table.
// No dependencies.
`default_nettype none
package gtp_pkg;

  typedef enum logic [1:0] {
    REQ_POSE  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_RESET = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ALIGN = 2'd1,
    MODE_DRIVE = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  // Sequencer states of the control step.
  typedef enum logic [3:0] {
    ST_IDLE, ST_VPRE, ST_VEC, ST_MAG, ST_DIST, ST_WRAP1, ST_WRAP2, ST_ERR,
    ST_ROT, ST_COS, ST_TURN, ST_SPD1, ST_SPD2, ST_SPD3, ST_OUT
  } state_t;

  // Signed 40-bit datapath word.
  typedef logic signed [39:0] word_t;

  // Signed 48-bit multiplier product.
  typedef logic signed [47:0] prod_t;

  localparam int CordicSteps = 16;
  localparam logic signed [39:0] PiQ16      = 40'sd205887;
  localparam logic signed [39:0] HalfPiQ16  = 40'sd102944;
  localparam logic signed [39:0] GainQ16    = 40'sd39797;
  localparam logic signed [39:0] InvGainQ30 = 40'sd652032875;

  // Arctangent of 2^-i in Q16 rad.
  function automatic logic signed [39:0] atan_q16(input logic [3:0] i);
    logic signed [39:0] r;
    case (i)
      4'd0:  r = 40'sd51472;
      4'd1:  r = 40'sd30386;
      4'd2:  r = 40'sd16055;
      4'd3:  r = 40'sd8150;
      4'd4:  r = 40'sd4091;
      4'd5:  r = 40'sd2047;
      4'd6:  r = 40'sd1024;
      4'd7:  r = 40'sd512;
      4'd8:  r = 40'sd256;
      4'd9:  r = 40'sd128;
      4'd10: r = 40'sd64;
      4'd11: r = 40'sd32;
      4'd12: r = 40'sd16;
      4'd13: r = 40'sd8;
      4'd14: r = 40'sd4;
      default: r = 40'sd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/gtp_mul.sv
// Shared signed multiplier with registered product for the controller.
// Depends on gtp_pkg for the product type.
`default_nettype none
module gtp_mul
  import gtp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output prod_t                   p_r
);

  prod_t p_nxt;

  // Operands are kept within 32 bits and products within 48 bits.
  always_comb begin
    logic signed [63:0] full;
    full  = a * b;
    p_nxt = full[47:0];
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/gtp_cordic.sv
// Iterative CORDIC shared by the vectoring (atan2, magnitude) and rotation (cos) passes.
// Depends on gtp_pkg for the arctangent table and datapath type.
`default_nettype none
module gtp_cordic
  import gtp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  step,
  input  wire logic  vec_mode,
  input  wire word_t x_in,
  input  wire word_t y_in,
  input  wire word_t z_in,
  input  wire logic [3:0] iter,
  output word_t      x_r,
  output word_t      y_r,
  output word_t      z_r
);

  word_t x_nxt, y_nxt, z_nxt;

  // One micro-rotation per cycle while step is high; direction from y (vectoring) or z (rotation).
  always_comb begin
    word_t dx, dy, a;
    logic  pos;
    dx  = x_r;
    dy  = y_r;
    dx  = y_r >>> iter;
    dy  = x_r >>> iter;
    a   = atan_q16(iter);
    pos = vec_mode ? !y_r[39] : !z_r[39];
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (load) begin
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
    end else if (step) begin
      if (vec_mode) begin
        x_nxt = pos ? x_r + dx : x_r - dx;
        y_nxt = pos ? y_r - dy : y_r + dy;
        z_nxt = pos ? z_r + a : z_r - a;
      end else begin
        x_nxt = pos ? x_r - dx : x_r + dx;
        y_nxt = pos ? y_r + dy : y_r - dy;
        z_nxt = pos ? z_r - a : z_r + a;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/go_to_point_motion_controller.sv
// Top level of the go-to-point motion controller: sequencer, registers, ports.
// Depends on gtp_pkg, gtp_cordic and gtp_mul.
`default_nettype none
// Rotate-then-drive go-to-point controller. Set-target, reset and unused
// requests and pose updates in idle or succeeded mode go straight to the
// output state. Every other pose update runs the 16-step vectoring CORDIC
// and a registered multiply for the distance; one that leaves the block
// aligning also wraps the heading and multiplies for the turn rate, and one
// that drives further runs the 16-step rotation CORDIC for the cosine and the
// speed multiplies. All run on one shared CORDIC unit and one multiplier. The
// input is ready only while the sequencer is idle. A result waits in the
// output register while the next item is taken and processed; only when a new
// result is ready and the previous one still waits does the sequencer hold.
module go_to_point_motion_controller
  import gtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], yaw[47:32]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // forward_speed[13:0], turn_rate[29:14],
                                       // distance[46:30], heading_err[62:47], zero[63]
  output logic [1:0]       out_tuser,  // mode[1:0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [2:0] RegGainLin = 3'd0, RegGainAlign = 3'd1, RegGainDrive = 3'd2,
    RegMaxSpd = 3'd3, RegMaxTurn = 3'd4, RegArrive = 3'd5, RegAim = 3'd6,
    RegRealign = 3'd7;

  // Result packing: speed 14, turn 16, distance 17, heading 16 = 63 -> 64 bits.

  logic [15:0] g_lin_r, g_aln_r, g_drv_r, arr_r;
  logic [13:0] vmax_r;
  logic [14:0] wmax_r, aim_r, real_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_lin_r <= 16'd4096; g_aln_r <= 16'd4096; g_drv_r <= 16'd2048;
      vmax_r <= 14'd1024; wmax_r <= 15'd8192; arr_r <= 16'd51;
      aim_r <= 15'd410; real_r <= 15'd2458;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegGainLin:   g_lin_r <= cfg_wdata;
        RegGainAlign: g_aln_r <= cfg_wdata;
        RegGainDrive: g_drv_r <= cfg_wdata;
        RegMaxSpd:    vmax_r  <= cfg_wdata[13:0];
        RegMaxTurn:   wmax_r  <= cfg_wdata[14:0];
        RegArrive:    arr_r   <= cfg_wdata;
        RegAim:       aim_r   <= cfg_wdata[14:0];
        RegRealign:   real_r  <= cfg_wdata[14:0];
        default:      ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic signed [15:0] tx_r, ty_r, tx_nxt, ty_nxt;
  logic signed [15:0] px_r, py_r, yaw_r, px_nxt, py_nxt, yaw_nxt;
  logic [3:0] it_r, it_nxt;
  word_t a_r, a_nxt;          // general scratch (angle / difference)
  logic [16:0] dist_r, dist_nxt;
  logic signed [15:0] err_r, err_nxt;
  logic [13:0] spd_r, spd_nxt;
  logic signed [15:0] turn_r, turn_nxt;
  logic [12:0] cos_r, cos_nxt;
  logic drive_r, drive_nxt;   // speed and drive gain apply
  logic ov_r, ov_nxt;
  logic [1:0] om_r, om_nxt;
  logic [13:0] os_r, os_nxt;
  logic signed [15:0] ot_r, ot_nxt, oe_r, oe_nxt;
  logic [16:0] od_r, od_nxt;

  logic c_load, c_step, c_vec;
  word_t cx_in, cy_in, cz_in, cx, cy, cz;
  logic signed [31:0] ma, mb;
  prod_t mp;

  gtp_cordic u_cordic (
    .clk(clk), .load(c_load), .step(c_step), .vec_mode(c_vec),
    .x_in(cx_in), .y_in(cy_in), .z_in(cz_in), .iter(it_r),
    .x_r(cx), .y_r(cy), .z_r(cz)
  );

  gtp_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = om_r;
  assign out_tdata  = {1'b0, oe_r, od_r, ot_r, os_r};

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; mode_r <= MODE_IDLE; tx_r <= '0; ty_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; mode_r <= mode_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt; yaw_r <= yaw_nxt; it_r <= it_nxt; a_r <= a_nxt;
    dist_r <= dist_nxt; err_r <= err_nxt; spd_r <= spd_nxt; turn_r <= turn_nxt;
    cos_r <= cos_nxt; drive_r <= drive_nxt; om_r <= om_nxt; os_r <= os_nxt;
    ot_r <= ot_nxt; od_r <= od_nxt; oe_r <= oe_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    word_t ex, ey, d, r, aerr, wlim;
    prod_t pr;
    logic [15:0] tg;
    state_nxt = state_r; mode_nxt = mode_r; tx_nxt = tx_r; ty_nxt = ty_r;
    px_nxt = px_r; py_nxt = py_r; yaw_nxt = yaw_r; it_nxt = it_r; a_nxt = a_r;
    dist_nxt = dist_r; err_nxt = err_r; spd_nxt = spd_r; turn_nxt = turn_r;
    cos_nxt = cos_r; drive_nxt = drive_r; ov_nxt = ov_r && !out_tready;
    om_nxt = om_r; os_nxt = os_r; ot_nxt = ot_r; od_nxt = od_r; oe_nxt = oe_r;
    c_load = 1'b0; c_step = 1'b0; c_vec = 1'b1;
    cx_in = '0; cy_in = '0; cz_in = '0; ma = '0; mb = '0;
    ex = 40'(($signed({tx_r[15], tx_r}) - $signed({px_r[15], px_r}))) <<< 8;
    ey = 40'(($signed({ty_r[15], ty_r}) - $signed({py_r[15], py_r}))) <<< 8;
    aerr = err_r[15] ? -40'(err_r) : 40'(err_r);
    wlim = $signed({25'd0, wmax_r});
    tg = drive_r ? g_drv_r : g_aln_r;
    d = '0; r = '0; pr = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          px_nxt = in_tdata[15:0]; py_nxt = in_tdata[31:16]; yaw_nxt = in_tdata[47:32];
          dist_nxt = '0; err_nxt = '0; spd_nxt = '0; turn_nxt = '0;
          state_nxt = ST_OUT;
          case (req_t'(in_tuser))
            REQ_SET: begin
              tx_nxt = in_tdata[15:0]; ty_nxt = in_tdata[31:16]; mode_nxt = MODE_ALIGN;
            end
            REQ_RESET: begin
              tx_nxt = '0; ty_nxt = '0; mode_nxt = MODE_IDLE;
            end
            REQ_POSE: begin
              if (mode_r == MODE_ALIGN || mode_r == MODE_DRIVE) state_nxt = ST_VPRE;
            end
            default: ;
          endcase
        end
      end
      ST_VPRE: begin
        // Quadrant pre-rotation into the right half plane.
        c_load = 1'b1;
        if (ex[39]) begin
          if (!ey[39]) begin cx_in = ey; cy_in = -ex; cz_in = HalfPiQ16; end
          else begin cx_in = -ey; cy_in = ex; cz_in = -HalfPiQ16; end
        end else begin
          cx_in = ex; cy_in = ey;
        end
        it_nxt = '0; state_nxt = ST_VEC;
      end
      ST_VEC: begin
        c_step = 1'b1; it_nxt = it_r + 4'd1;
        if (it_r == 4'(CordicSteps - 1)) state_nxt = ST_MAG;
      end
      ST_MAG: begin
        ma = cx[31:0]; mb = 32'(GainQ16); a_nxt = cz;
        state_nxt = ST_DIST;
      end
      ST_DIST: begin
        pr = (mp + 48'sd8388608) >>> 24;
        r = pr[39:0];
        dist_nxt = (r > 40'sd131071) ? 17'd131071 : r[16:0];
        if (((r > 40'sd131071) ? 17'd131071 : r[16:0]) <= {1'b0, arr_r}) begin
          mode_nxt = MODE_DONE; state_nxt = ST_OUT;
        end else begin
          a_nxt = a_r - (40'(yaw_r) <<< 3);
          state_nxt = ST_WRAP1;
        end
      end
      ST_WRAP1, ST_WRAP2: begin
        d = a_r;
        if (d > PiQ16) d = d - (PiQ16 <<< 1);
        else if (d <= -PiQ16) d = d + (PiQ16 <<< 1);
        a_nxt = d;
        state_nxt = (state_r == ST_WRAP1) ? ST_WRAP2 : ST_ERR;
      end
      ST_ERR: begin
        r = (a_r + 40'sd4) >>> 3;
        err_nxt = r[15:0];
        drive_nxt = 1'b0;
        // Mode decision needs |err|; computed next cycle via aerr.
        state_nxt = ST_ROT;
        it_nxt = '0;
      end
      ST_ROT: begin
        // Mode decision, then cos CORDIC load.
        drive_nxt = 1'b0;
        if (mode_r == MODE_ALIGN && aerr > 40'(aim_r)) begin
          state_nxt = ST_TURN;
        end else if (aerr > 40'(real_r)) begin
          mode_nxt = MODE_ALIGN; state_nxt = ST_TURN;
        end else begin
          mode_nxt = MODE_DRIVE; drive_nxt = 1'b1;
          c_load = 1'b1; c_vec = 1'b0;
          cx_in = InvGainQ30; cy_in = '0; cz_in = 40'(err_r) <<< 3;
          state_nxt = ST_COS;
        end
      end
      ST_COS: begin
        c_vec = 1'b0; c_step = 1'b1; it_nxt = it_r + 4'd1;
        if (it_r == 4'(CordicSteps - 1)) state_nxt = ST_TURN;
      end
      ST_TURN: begin
        // Cos result to Q12 and turn product.
        d = (40'(err_r) <<< 3);
        if (d >= HalfPiQ16 || d <= -HalfPiQ16) cos_nxt = '0;
        else begin
          r = cx[39] ? '0 : ((cx > (40'sd1 <<< 30)) ? (40'sd1 <<< 30) : cx);
          r = (r + 40'sd131072) >>> 18;
          cos_nxt = r[12:0];
        end
        ma = {16'd0, tg}; mb = 32'(err_r);
        state_nxt = ST_SPD1;
      end
      ST_SPD1: begin
        pr = (mp + 48'sd4096) >>> 13;
        r = pr[39:0];
        if (r > wlim) r = wlim;
        else if (r < -wlim) r = -wlim;
        turn_nxt = r[15:0];
        ma = {16'd0, g_lin_r}; mb = {15'd0, dist_r};
        state_nxt = drive_r ? ST_SPD2 : ST_OUT;
      end
      ST_SPD2: begin
        pr = (mp + 48'sd512) >>> 10;
        r = pr[39:0];
        if (r > 40'(vmax_r)) r = 40'(vmax_r);
        ma = r[31:0]; mb = {19'd0, cos_r};
        state_nxt = ST_SPD3;
      end
      ST_SPD3: begin
        // Clamped speed scaled by the cosine.
        pr = (mp + 48'sd2048) >>> 12;
        spd_nxt = pr[13:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          om_nxt = mode_r; os_nxt = spd_r; ot_nxt = turn_r; od_nxt = dist_r;
          oe_nxt = err_r;
          ov_nxt = 1'b1; drive_nxt = 1'b0; spd_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
